/* rtl/tun_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_pkg
// Widths, pipeline payload types and helpers shared by the triangle unit
// normal datapath.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int COORD_WIDTH      = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int FIELD_W          = 16;  // input field width
  localparam int OUT_W            = 16;  // output component width

  localparam int CW   = COORD_WIDTH;
  localparam int F    = NORMAL_FRAC_BITS;
  localparam int EW   = CW + 1;            // edge
  localparam int PW   = 2 * EW;            // edge product
  localparam int NW   = PW + 1;            // signed cross component
  localparam int MW   = PW;                // cross magnitude
  localparam int SQW  = 2 * MW;            // squared magnitude
  localparam int LW   = SQW + 2;           // squared length
  localparam int RW   = (LW + 2 * F + 1) / 2;  // root bits, one per root cell
  localparam int XEW  = 2 * RW;            // radicand, even width
  localparam int REMW = RW + 3;            // root remainder
  localparam int QW   = F + 1;             // quotient bits, one per divide cell
  localparam int NUMW = MW + 2 * F;        // dividend
  localparam int DW   = ((NUMW > RW + F) ? NUMW : RW + F) + 1;
  localparam int VW   = 33;                // signed quotient before truncation

  typedef struct packed {
    logic                valid;
    logic                degen;
    logic [2:0]          neg;
    logic [2:0][MW-1:0]  mag;
  } side_t;

  typedef struct packed {
    side_t               side;
    logic [XEW-1:0]      x;
    logic [REMW-1:0]     rem;
    logic [RW-1:0]       root;
  } sq_t;

  typedef struct packed {
    logic                valid;
    logic                degen;
    logic [2:0]          neg;
    logic [2:0][DW-1:0]  rem;
    logic [DW-1:0]       dsh;
    logic [2:0][QW-1:0]  q;
  } dv_t;

  // Low CW bits of a field, sign-extended; a field narrower than CW is
  // taken as it stands, zero-extended.
  function automatic logic signed [EW-1:0] coord(input logic [FIELD_W-1:0] raw);
    logic [CW+FIELD_W-1:0] t;
    logic [CW-1:0]         v;
    t = {{CW{1'b0}}, raw};
    v = t[CW-1:0];
    return $signed({v[CW-1], v});
  endfunction

endpackage

/* rtl/tun_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_front
// Edges, exact cross product, magnitudes and squared length in five
// registered stages.
// ----------------------------------------------------------------------------
module tun_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        valid_i,
  input  logic [9*tun_pkg::FIELD_W-1:0] data_i,
  output tun_pkg::side_t              side_o,
  output logic [tun_pkg::LW-1:0]      len2_o
);

  localparam int EW  = tun_pkg::EW;
  localparam int PW  = tun_pkg::PW;
  localparam int NW  = tun_pkg::NW;
  localparam int MW  = tun_pkg::MW;
  localparam int SQW = tun_pkg::SQW;
  localparam int LW  = tun_pkg::LW;
  localparam int FW  = tun_pkg::FIELD_W;

  logic [4:0] v_r;
  logic signed [2:0][EW-1:0] e1_r, e2_r;
  logic signed [2:0][PW-1:0] p0_r, p1_r;
  logic [2:0][MW-1:0] mag3_r, mag4_r, mag5_r;
  logic [2:0] neg3_r, neg4_r, neg5_r;
  logic degen3_r, degen4_r, degen5_r;
  logic [2:0][SQW-1:0] sq_r;
  logic [LW-1:0] len2_r;

  logic [2:0][NW-1:0] n_nxt;
  logic [2:0][NW-1:0] nabs;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_nxt[i] = {p0_r[i][PW-1], p0_r[i]} - {p1_r[i][PW-1], p1_r[i]};
      nabs[i]  = n_nxt[i][NW-1] ? (NW'(0) - n_nxt[i]) : n_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= tun_pkg::coord(data_i[(3+i)*FW +: FW]) -
                   tun_pkg::coord(data_i[i*FW +: FW]);
        e2_r[i] <= tun_pkg::coord(data_i[(6+i)*FW +: FW]) -
                   tun_pkg::coord(data_i[i*FW +: FW]);
      end
      // elements of a packed array read back unsigned
      for (int i = 0; i < 3; i++) begin
        p0_r[i] <= $signed(e1_r[(i+1)%3]) * $signed(e2_r[(i+2)%3]);
        p1_r[i] <= $signed(e1_r[(i+2)%3]) * $signed(e2_r[(i+1)%3]);
      end
      for (int i = 0; i < 3; i++) begin
        mag3_r[i] <= nabs[i][MW-1:0];
        neg3_r[i] <= n_nxt[i][NW-1];
      end
      degen3_r <= (n_nxt[0] == '0) && (n_nxt[1] == '0) && (n_nxt[2] == '0);
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= {{MW{1'b0}}, mag3_r[i]} * {{MW{1'b0}}, mag3_r[i]};
      end
      mag4_r   <= mag3_r;
      neg4_r   <= neg3_r;
      degen4_r <= degen3_r;
      len2_r   <= LW'(sq_r[0]) + LW'(sq_r[1]) + LW'(sq_r[2]);
      mag5_r   <= mag4_r;
      neg5_r   <= neg4_r;
      degen5_r <= degen4_r;
    end
  end

  assign side_o.valid = v_r[4];
  assign side_o.degen = degen5_r;
  assign side_o.neg   = neg5_r;
  assign side_o.mag   = mag5_r;
  assign len2_o       = len2_r;

endmodule

/* rtl/tun_sqrt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_sqrt_cell
// One digit of the integer square root; takes two radicand bits per cycle while en is high.
// ----------------------------------------------------------------------------
module tun_sqrt_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  tun_pkg::sq_t d_i,
  output tun_pkg::sq_t q_o
);

  localparam int RW   = tun_pkg::RW;
  localparam int XEW  = tun_pkg::XEW;
  localparam int REMW = tun_pkg::REMW;

  tun_pkg::sq_t q_r, q_nxt;
  logic [REMW-1:0] rem2, trial;
  logic            take;

  always_comb begin
    rem2  = {d_i.rem[REMW-3:0], d_i.x[XEW-1:XEW-2]};
    trial = REMW'({d_i.root, 2'b01});
    take  = rem2 >= trial;
    q_nxt      = d_i;
    q_nxt.x    = {d_i.x[XEW-3:0], 2'b00};
    q_nxt.rem  = take ? (rem2 - trial) : rem2;
    q_nxt.root = {d_i.root[RW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.side.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule

/* rtl/tun_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_div_cell
// One restoring quotient bit for all three components against a shared
// shifted divisor.
// ----------------------------------------------------------------------------
module tun_div_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  tun_pkg::dv_t d_i,
  output tun_pkg::dv_t q_o
);

  localparam int QW = tun_pkg::QW;

  tun_pkg::dv_t q_r, q_nxt;

  always_comb begin
    q_nxt     = d_i;
    q_nxt.dsh = d_i.dsh >> 1;
    for (int i = 0; i < 3; i++) begin
      if (d_i.rem[i] >= d_i.dsh) begin
        q_nxt.rem[i] = d_i.rem[i] - d_i.dsh;
        q_nxt.q[i]   = {d_i.q[i][QW-2:0], 1'b1};
      end else begin
        q_nxt.q[i]   = {d_i.q[i][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;

endmodule

/* rtl/triangle_unit_normal_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_unit_normal_unit
// Unit face normal of one triangle per transaction, Q8.8 in, Q1.14 out.
// ----------------------------------------------------------------------------
// Takes one triangle per cycle while the pipeline is not stalled and returns
// its normal through 5 front stages, 49 square-root cells at the default
// widths, 15 divide cells and the output register. The whole pipeline moves
// together: it stalls only while a result sits in the output register and
// out_tready is low. Degenerate triangles return zero components with
// out_tuser set.
module triangle_unit_normal_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (16 bits each)
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // normal_x, normal_y, normal_z (16 bits each)
  output logic [47:0]  out_tdata,
  // degenerate
  output logic         out_tuser
);

  localparam int RW    = tun_pkg::RW;
  localparam int QW    = tun_pkg::QW;
  localparam int F     = tun_pkg::F;
  localparam int XEW   = tun_pkg::XEW;
  localparam int DW    = tun_pkg::DW;
  localparam int VW    = tun_pkg::VW;
  localparam int OUT_W = tun_pkg::OUT_W;

  logic en;
  tun_pkg::side_t         side;
  logic [tun_pkg::LW-1:0] len2;
  tun_pkg::sq_t           sq [RW+1];
  tun_pkg::dv_t           dv [QW+1];
  tun_pkg::sq_t           sq_last;

  logic                   out_valid_r;
  logic [47:0]            out_data_r;
  logic                   out_user_r;
  logic [VW-1:0]          val [3];

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  tun_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_tvalid),
    .data_i  (in_tdata),
    .side_o  (side),
    .len2_o  (len2)
  );

  always_comb begin
    sq[0]      = '0;
    sq[0].side = side;
    sq[0].x    = XEW'({len2, {(2*F){1'b0}}});
  end

  for (genvar g = 0; g < RW; g++) begin : g_sqrt
    tun_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (sq[g]),
      .q_o   (sq[g+1])
    );
  end

  always_comb begin
    sq_last     = sq[RW];
    dv[0]       = '0;
    dv[0].valid = sq_last.side.valid;
    dv[0].degen = sq_last.side.degen;
    dv[0].neg   = sq_last.side.neg;
    dv[0].dsh   = DW'({sq_last.root, {F{1'b0}}});
    for (int i = 0; i < 3; i++) begin
      dv[0].rem[i] = DW'({sq_last.side.mag[i], {(2*F){1'b0}}});
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_div
    tun_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (dv[g]),
      .q_o   (dv[g+1])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      val[i] = dv[QW].neg[i] ? (VW'(0) - VW'(dv[QW].q[i])) : VW'(dv[QW].q[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv[QW].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        out_data_r[i*OUT_W +: OUT_W] <= dv[QW].degen ? '0 : val[i][OUT_W-1:0];
      end
      out_user_r <= dv[QW].degen;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
